### hw/rtl/utf8e_pkg.sv
// Package for the UTF-8 byte encoder: length limits, lead byte tables,
// the encoded-word type and the encode function.
// No dependencies.
package utf8e_pkg;

    localparam int unsigned MAX_BYTES = 6;

    // Upper bound of each encoding length (inclusive)
    localparam logic [31:0] LIM_1B = 32'h0000_007F;
    localparam logic [31:0] LIM_2B = 32'h0000_07FF;
    localparam logic [31:0] LIM_3B = 32'h0000_FFFF;
    localparam logic [31:0] LIM_4B = 32'h001F_FFFF;
    localparam logic [31:0] LIM_5B = 32'h03FF_FFFF;
    localparam logic [31:0] LIM_6B = 32'h7FFF_FFFF;

    // Replacement character U+FFFD
    localparam logic [7:0] REPL_B0 = 8'hEF;
    localparam logic [7:0] REPL_B1 = 8'hBF;
    localparam logic [7:0] REPL_B2 = 8'hBD;
    localparam logic [2:0] REPL_LEN = 3'd3;

    localparam logic [7:0] CONT_TAG = 8'h80;

    // Lead byte prefix and payload mask, indexed by encoding length
    localparam logic [7:0] LEAD_PREFIX [0:6] =
        '{8'h00, 8'h00, 8'hC0, 8'hE0, 8'hF0, 8'hF8, 8'hFC};
    localparam logic [7:0] LEAD_MASK [0:6] =
        '{8'h00, 8'h7F, 8'h1F, 8'h0F, 8'h07, 8'h03, 8'h01};

    typedef logic [2:0] len_t;

    // One fully encoded character, lead byte in entry 0
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        len_t                      len;
    } enc_word_t;

    function automatic enc_word_t encode_char(logic [31:0] c);
        enc_word_t           w;
        len_t                n;
        len_t                k;
        logic [5:0][5:0]     g;
        w = '0;
        // six-bit payload groups, least significant first
        for (int i = 0; i < 5; i++)
        begin
            g[i] = c[6*i +: 6];
        end
        g[5] = {4'b0000, c[31:30]};

        if (c[31])
        begin
            w.bytes[0] = REPL_B0;
            w.bytes[1] = REPL_B1;
            w.bytes[2] = REPL_B2;
            w.len      = REPL_LEN;
        end
        else
        begin
            if ((c & ~LIM_1B) == 32'd0)      n = 3'd1;
            else if ((c & ~LIM_2B) == 32'd0) n = 3'd2;
            else if ((c & ~LIM_3B) == 32'd0) n = 3'd3;
            else if ((c & ~LIM_4B) == 32'd0) n = 3'd4;
            else if ((c & ~LIM_5B) == 32'd0) n = 3'd5;
            else                             n = 3'd6;

            // lead byte: ASCII passes seven bits, longer forms take the top group
            if (n == 3'd1)
            begin
                w.bytes[0] = {1'b0, c[6:0]};
            end
            else
            begin
                k = n - 3'd1;
                w.bytes[0] = LEAD_PREFIX[n] | ({2'b00, g[k]} & LEAD_MASK[n]);
            end

            // continuation bytes, most significant group first
            for (int i = 1; i < MAX_BYTES; i++)
            begin
                if (3'(i) < n)
                begin
                    k = n - 3'(i) - 3'd1;
                    w.bytes[i] = CONT_TAG | {2'b00, g[k]};
                end
            end
            w.len = n;
        end
        return w;
    endfunction

endpackage

### hw/rtl/utf8e_if.sv
// Handshake channels of the UTF-8 encoder: code input and byte output.
// No dependencies.
interface utf8e_code_if;
    logic        valid;
    logic        ready;
    logic [31:0] code_point;

    modport source (output valid, output code_point, input ready);
    modport sink   (input valid, input code_point, output ready);
endinterface

interface utf8e_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (output valid, output out_byte, output last_byte, input ready);
    modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

### hw/rtl/utf8_byte_encoder_top.sv
// UTF-8 byte encoder, original six-byte scheme. A code passes the input register
// and then the serializer before its lead byte is offered on the output.
// Throughput: one byte per cycle while the output is ready; a code of n bytes holds
// the output until all its bytes are taken, so one-byte codes run at one per cycle.
// The rate is set by the single byte output of the serializer.
// Reset (rst_n, async, low) empties the input register and the serializer.
module utf8_byte_encoder_top
(
    input  logic         clk,
    input  logic         rst_n,
    utf8e_code_if.sink   in_ch,
    utf8e_byte_if.source out_ch
);

    utf8e_pkg::enc_word_t word;
    logic                 word_valid;
    logic                 word_take;

    // Input register and encoder
    utf8e_encode u_encode
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .word       (word),
        .word_valid (word_valid),
        .word_take  (word_take)
    );

    // Byte serializer
    utf8e_serializer u_serializer
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .word       (word),
        .word_valid (word_valid),
        .word_take  (word_take),
        .out_ch     (out_ch)
    );

endmodule

### hw/rtl/utf8e_encode.sv
// Input register of the UTF-8 encoder and the encode logic behind it.
// Depends on utf8e_pkg and utf8e_if.
module utf8e_encode
(
    input  logic                clk,
    input  logic                rst_n,
    utf8e_code_if.sink          in_ch,
    output utf8e_pkg::enc_word_t word,
    output logic                word_valid,
    input  logic                word_take
);

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] code_reg;

    // Accept a new word whenever the held one is empty or leaving
    assign in_ch.ready = !valid_reg || word_take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ch.ready)
        begin
            valid_next = in_ch.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            code_reg <= in_ch.code_point;
        end
    end

    assign word       = utf8e_pkg::encode_char(code_reg);
    assign word_valid = valid_reg;

endmodule

### hw/rtl/utf8e_serializer.sv
// Byte serializer: holds one encoded character and sends it a byte a word.
// Depends on utf8e_pkg and utf8e_if.
module utf8e_serializer
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  utf8e_pkg::enc_word_t word,
    input  logic                 word_valid,
    output logic                 word_take,
    utf8e_byte_if.source         out_ch
);

    logic [utf8e_pkg::MAX_BYTES-1:0][7:0] pending_bytes_reg;
    utf8e_pkg::len_t bytes_left_reg;
    utf8e_pkg::len_t bytes_left_next;
    logic [2:0]      idx_reg;
    logic [2:0]      idx_next;
    logic            out_fire;
    logic            is_last;

    assign is_last  = (bytes_left_reg == 3'd1);
    assign out_fire = out_ch.valid && out_ch.ready;

    // Load the next character when empty or on the final byte going out
    assign word_take = word_valid && (bytes_left_reg == 3'd0 || (out_fire && is_last));

    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        idx_next        = idx_reg;
        if (word_take)
        begin
            bytes_left_next = word.len;
            idx_next        = 3'd0;
        end
        else if (out_fire)
        begin
            bytes_left_next = bytes_left_reg - 3'd1;
            idx_next        = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= 3'd0;
            idx_reg        <= 3'd0;
        end
        else
        begin
            bytes_left_reg <= bytes_left_next;
            idx_reg        <= idx_next;
        end
    end

    // Byte buffer, written whole on load
    always_ff @(posedge clk)
    begin
        if (word_take)
        begin
            pending_bytes_reg <= word.bytes;
        end
    end

    assign out_ch.valid     = (bytes_left_reg != 3'd0);
    assign out_ch.out_byte  = pending_bytes_reg[idx_reg];
    assign out_ch.last_byte = is_last;

    // Checks
    a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_left_reg <= 3'd6)
        else $error("bytes_left out of range");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> ({1'b0, idx_reg} + {1'b0, bytes_left_reg}) <= 4'd6)
        else $error("byte index runs past buffer");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && is_last && !word_take) |=> !out_ch.valid)
        else $error("serializer did not empty after last byte");

    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !is_last) |=> (idx_reg == $past(idx_reg) + 3'd1))
        else $error("byte index did not advance");

    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        word_take |=> (idx_reg == 3'd0 && bytes_left_reg != 3'd0))
        else $error("load did not start a new character");

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// Testbench for utf8_byte_encoder_top: drives wide character codes and checks the
// byte stream against a directed table and a local encoder under mixed idle and stall.
// Depends on utf8e_pkg, the utf8e_code_if/utf8e_byte_if channels and the RTL.
module testbench;

    localparam int unsigned RANDOM_PER_PHASE = 45;
    localparam int unsigned HOLD_CODES       = 16;
    localparam int unsigned HOLD_LEN         = 300;

    // One character's encoding, lead byte in entry 0
    typedef struct packed {
        logic [utf8e_pkg::MAX_BYTES-1:0][7:0] b;
        logic [2:0]                           n;
    } char_bytes_t;

    // One expected output byte
    typedef struct {
        logic [31:0] cp;
        int unsigned idx;
        logic [7:0]  val;
        logic        last;
    } byte_exp_t;

    // Directed stimulus; seq holds the known bytes right-justified, lead first
    typedef struct packed {
        logic [31:0] cp;
        logic        known;
        logic [2:0]  n;
        logic [47:0] seq;
    } stim_row_t;

    stim_row_t directed_rows [22] = '{
        '{32'h0000_0000, 1'b1, 3'd1, 48'h00},            // zero code
        '{32'h0000_007F, 1'b1, 3'd1, 48'h7F},
        '{32'h0000_0080, 1'b1, 3'd2, 48'hC280},
        '{32'h0000_07FF, 1'b1, 3'd2, 48'hDFBF},
        '{32'h0000_0800, 1'b1, 3'd3, 48'hE0A080},
        '{32'h0000_FFFF, 1'b1, 3'd3, 48'hEFBFBF},
        '{32'h0001_0000, 1'b1, 3'd4, 48'hF0908080},
        '{32'h001F_FFFF, 1'b1, 3'd4, 48'hF7BFBFBF},
        '{32'h0020_0000, 1'b1, 3'd5, 48'hF888808080},
        '{32'h03FF_FFFF, 1'b1, 3'd5, 48'hFBBFBFBFBF},
        '{32'h0400_0000, 1'b1, 3'd6, 48'hFC8480808080},
        '{32'h7FFF_FFFF, 1'b1, 3'd6, 48'hFDBFBFBFBFBF},
        '{32'h8000_0000, 1'b1, 3'd3, 48'hEFBFBD},        // invalid codes
        '{32'hFFFF_FFFF, 1'b1, 3'd3, 48'hEFBFBD},
        '{32'hAAAA_AAAA, 1'b1, 3'd3, 48'hEFBFBD},
        '{32'h0000_0041, 1'b0, 3'd0, 48'h0},
        '{32'h0000_20AC, 1'b0, 3'd0, 48'h0},
        '{32'h0000_D800, 1'b0, 3'd0, 48'h0},
        '{32'h0000_FFFD, 1'b0, 3'd0, 48'h0},
        '{32'h0010_FFFF, 1'b0, 3'd0, 48'h0},
        '{32'h1234_5678, 1'b0, 3'd0, 48'h0},
        '{32'h5555_5555, 1'b0, 3'd0, 48'h0}
    };

    logic clk = 1'b0;
    logic rst_n;

    utf8e_code_if code_ch ();
    utf8e_byte_if byte_ch ();

    utf8_byte_encoder_top DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (code_ch),
        .out_ch (byte_ch)
    );

    byte_exp_t   expected_bytes [$];
    int unsigned send_idle_pct  = 0;
    int unsigned stall_pct      = 0;
    int unsigned hold_req       = 0;
    int unsigned mismatch_count = 0;
    int unsigned bytes_checked  = 0;
    int unsigned invalid_count  = 0;
    int unsigned len_count [1:6] = '{0, 0, 0, 0, 0, 0};

    always #2 clk = ~clk;

    // Encoder used for prediction
    function automatic char_bytes_t encode_expected(logic [31:0] cp);
        char_bytes_t r;
        int unsigned nb;
        logic [7:0]  lead_pfx;
        r = '0;
        if (cp[31])
        begin
            r.b[0] = utf8e_pkg::REPL_B0;
            r.b[1] = utf8e_pkg::REPL_B1;
            r.b[2] = utf8e_pkg::REPL_B2;
            r.n    = 3'd3;
            return r;
        end
        if (cp < 32'h80)            nb = 1;
        else if (cp < 32'h800)      nb = 2;
        else if (cp < 32'h1_0000)   nb = 3;
        else if (cp < 32'h20_0000)  nb = 4;
        else if (cp < 32'h400_0000) nb = 5;
        else                        nb = 6;
        if (nb == 1)
        begin
            r.b[0] = cp[7:0];
        end
        else
        begin
            // nb ones then a zero, followed by whatever payload is left on top
            lead_pfx = 8'hFF << (8 - nb);
            r.b[0] = lead_pfx | 8'(cp >> (6 * (nb - 1)));
            for (int i = 1; i < nb; i++)
            begin
                r.b[i] = 8'h80 | (8'(cp >> (6 * (nb - 1 - i))) & 8'h3F);
            end
        end
        r.n = 3'(nb);
        return r;
    endfunction

    function automatic void queue_char(logic [31:0] cp, char_bytes_t enc);
        byte_exp_t e;
        for (int i = 0; i < enc.n; i++)
        begin
            e.cp   = cp;
            e.idx  = i;
            e.val  = enc.b[i];
            e.last = (i == enc.n - 1);
            expected_bytes.push_back(e);
        end
        if (cp[31]) invalid_count++;
        else        len_count[enc.n]++;
    endfunction

    // Length class (or an invalid code) first, then a bound or a random value inside it
    function automatic logic [31:0] pick_code();
        logic [31:0] lo;
        logic [31:0] hi;
        int unsigned cls;
        cls = $urandom_range(6);
        case (cls)
            0:       begin lo = 32'd0;                  hi = utf8e_pkg::LIM_1B; end
            1:       begin lo = utf8e_pkg::LIM_1B + 1; hi = utf8e_pkg::LIM_2B; end
            2:       begin lo = utf8e_pkg::LIM_2B + 1; hi = utf8e_pkg::LIM_3B; end
            3:       begin lo = utf8e_pkg::LIM_3B + 1; hi = utf8e_pkg::LIM_4B; end
            4:       begin lo = utf8e_pkg::LIM_4B + 1; hi = utf8e_pkg::LIM_5B; end
            5:       begin lo = utf8e_pkg::LIM_5B + 1; hi = utf8e_pkg::LIM_6B; end
            default: return $urandom() | 32'h8000_0000;
        endcase
        case ($urandom_range(7))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    // Offer one code, with random idle cycles ahead of it
    task automatic send_code(logic [31:0] cp);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            code_ch.valid <= 1'b0;
            @(negedge clk);
        end
        code_ch.valid      <= 1'b1;
        code_ch.code_point <= cp;
        do
            @(posedge clk);
        while (!code_ch.ready);
    endtask

    task automatic send_random();
        logic [31:0] cp;
        cp = pick_code();
        queue_char(cp, encode_expected(cp));
        send_code(cp);
    endtask

    // Stop offering and wait for every expected byte
    task automatic wait_drained();
        @(negedge clk);
        code_ch.valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Output ready: random stalls, or a long hold-off when requested
    initial
    begin : byte_sink
        int unsigned held;
        byte_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req != 0)
            begin
                byte_ch.ready <= 1'b0;
                held = 0;
                while (held < hold_req)
                begin
                    @(negedge clk);
                    held++;
                end
                hold_req = 0;
            end
            byte_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Compare each accepted byte with the oldest expectation
    always @(posedge clk)
    begin
        byte_exp_t want;
        if (rst_n && byte_ch.valid && byte_ch.ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected byte %02h last=%0b",
                             byte_ch.out_byte, byte_ch.last_byte);
            end
            else
            begin
                want = expected_bytes.pop_front();
                bytes_checked++;
                if (byte_ch.out_byte !== want.val || byte_ch.last_byte !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: code %08h byte %0d: expected %02h/%0b, got %02h/%0b",
                                 want.cp, want.idx, want.val, want.last,
                                 byte_ch.out_byte, byte_ch.last_byte);
                end
            end
        end
    end

    // Main sequence
    initial
    begin : main_seq
        char_bytes_t enc;
        int unsigned nb;
        int unsigned idle_mix [4];
        int unsigned stall_mix [4];
        idle_mix  = '{0, 61, 0, 38};
        stall_mix = '{0, 0, 61, 38};
        rst_n              = 1'b0;
        code_ch.valid      = 1'b0;
        code_ch.code_point = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed table, no idling
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].known)
            begin
                enc = '0;
                nb  = directed_rows[r].n;
                for (int i = 0; i < nb; i++)
                    enc.b[i] = directed_rows[r].seq[8 * (nb - 1 - i) +: 8];
                enc.n = 3'(nb);
            end
            else
            begin
                enc = encode_expected(directed_rows[r].cp);
            end
            queue_char(directed_rows[r].cp, enc);
            send_code(directed_rows[r].cp);
        end
        wait_drained();

        // random codes under each idle/stall mix
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = idle_mix[ph];
            stall_pct     = stall_mix[ph];
            repeat (RANDOM_PER_PHASE) send_random();
            wait_drained();
            if (ph == 0)
            begin
                // output held off while codes keep coming, input must back up
                hold_req = HOLD_LEN;
                repeat (HOLD_CODES) send_random();
                wait_drained();
            end
        end

        $display("Encoded %0d codes of one to six bytes (%0d/%0d/%0d/%0d/%0d/%0d), %0d invalid.",
                 len_count[1] + len_count[2] + len_count[3] + len_count[4]
                 + len_count[5] + len_count[6] + invalid_count,
                 len_count[1], len_count[2], len_count[3], len_count[4],
                 len_count[5], len_count[6], invalid_count);
        $display("Checked %0d bytes under four idle/stall mixes and a %0d-cycle output hold-off.",
                 bytes_checked, HOLD_LEN);
        if (mismatch_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("%0d mismatches", mismatch_count);
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("TIMEOUT: %0d bytes still expected", expected_bytes.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
